@@ hw/rtl/was_pkg.sv @@
// Package for the windowed average smoother.
// Holds the beat types, the sizing constants and the channel indexes.
// Depends on nothing else.
`default_nettype none

package was_pkg;

   // Sizing of samples, accumulators and the window count.
   localparam int unsigned SAMPLE_BITS        = 16;
   localparam int unsigned MAX_WINDOW_SAMPLES = 65535;
   localparam int unsigned SUM_BITS           = 32;
   localparam int unsigned COUNT_BITS         = 16;
   localparam int unsigned MEAN_BITS          = 16;
   localparam int unsigned NUM_CHANNELS       = 3;

   // The bit-serial divider produces one quotient bit per step.
   localparam int unsigned DIV_STEPS = MEAN_BITS;
   localparam int unsigned STEP_BITS = $clog2(DIV_STEPS);

   localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
   localparam logic [COUNT_BITS-1:0] WINDOW_FULL = COUNT_BITS'(MAX_WINDOW_SAMPLES);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIV_STEPS - 1);

   // Channel slots in the accumulator and divider arrays.
   localparam int unsigned CH_X        = 0;
   localparam int unsigned CH_Y        = 1;
   localparam int unsigned CH_THROTTLE = 2;

   // One input beat: three samples and the end-of-window flag.
   typedef struct packed {
      logic [15:0] accel_x_sample;
      logic [15:0] accel_y_sample;
      logic [15:0] throttle_sample;
      logic        window_last;
   } was_req_type;

   // One result beat, produced at the close of each window.
   typedef struct packed {
      logic [15:0] accel_x_smoothed;
      logic [15:0] accel_y_smoothed;
      logic [15:0] throttle_mean;
      logic        window_overflowed;
   } was_rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/windowed_average_smoother.sv @@
// Windowed average smoother: top level with accumulators and bit-serial divider.
// Depends on was_pkg for the beat types and sizing constants.
// Contains the whole datapath and its controller.
`default_nettype none

// The block sums three 16-bit channels over a window and, on the beat marked
// window_last, divides each sum by the sample count. The two acceleration
// means are blended half and half with the previous result; the throttle mean
// is passed through. Beats that do not close a window are taken one per
// cycle while the block is accumulating. After a closing beat is taken, the
// input stalls while the shared-shape restoring divider (one unit per
// channel, run side by side) shifts in one quotient bit per cycle, and then
// until the result register is loaded. If the previous result is still
// stalled on the output, the load waits for it. Once a window holds
// 65535 samples, further samples in it are discarded and the result is
// flagged with window_overflowed. No clearing pass is needed after reset.
module windowed_average_smoother
   import was_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire was_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output was_rsp_type      rsp_data
);

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_DIV,
      ST_SEND
   } state_type;

   state_type state_ff, state_in;

   logic [SUM_BITS-1:0]   sum_ff [NUM_CHANNELS];
   logic [SUM_BITS-1:0]   sum_in [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  dropped_ff, dropped_in;
   logic [MEAN_BITS-1:0]  smooth_x_ff, smooth_x_in;
   logic [MEAN_BITS-1:0]  smooth_y_ff, smooth_y_in;

   // Divider registers: partial remainder and the dividend/quotient shifter.
   logic [MEAN_BITS-1:0]  div_rem_ff   [NUM_CHANNELS];
   logic [MEAN_BITS-1:0]  div_rem_in   [NUM_CHANNELS];
   logic [MEAN_BITS-1:0]  div_shift_ff [NUM_CHANNELS];
   logic [MEAN_BITS-1:0]  div_shift_in [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] divisor_ff, divisor_in;
   logic                  div_dropped_ff, div_dropped_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   was_rsp_type           rsp_data_ff, rsp_data_in;

   logic [15:0]           sample   [NUM_CHANNELS];
   logic [SUM_BITS-1:0]   sum_upd  [NUM_CHANNELS];
   logic [MEAN_BITS:0]    trial    [NUM_CHANNELS];
   logic [MEAN_BITS-1:0]  mean     [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] count_upd;
   logic                  dropped_upd;
   logic                  window_full;
   logic                  req_accept;
   logic                  rsp_free;

   assign req_stall  = (state_ff != ST_ACCUM);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Masked samples and the window sums including the current beat.
   assign sample[CH_X]        = req_data.accel_x_sample & SAMPLE_MASK;
   assign sample[CH_Y]        = req_data.accel_y_sample & SAMPLE_MASK;
   assign sample[CH_THROTTLE] = req_data.throttle_sample & SAMPLE_MASK;

   assign window_full = (count_ff == WINDOW_FULL);
   assign count_upd   = window_full ? count_ff : count_ff + 1'b1;
   assign dropped_upd = dropped_ff || window_full;

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         sum_upd[c] = window_full ? sum_ff[c]
                                  : sum_ff[c] + {{(SUM_BITS - 16){1'b0}}, sample[c]};
         // One restoring step: bring down the next dividend bit and compare.
         trial[c]   = {div_rem_ff[c], div_shift_ff[c][MEAN_BITS-1]};
         // An empty window reads as a mean of zero.
         mean[c]    = (divisor_ff == '0) ? '0 : div_shift_ff[c];
      end
   end

   // Next-state and datapath control.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      dropped_in     = dropped_ff;
      smooth_x_in    = smooth_x_ff;
      smooth_y_in    = smooth_y_ff;
      divisor_in     = divisor_ff;
      div_dropped_in = div_dropped_ff;
      step_in        = step_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         sum_in[c]       = sum_ff[c];
         div_rem_in[c]   = div_rem_ff[c];
         div_shift_in[c] = div_shift_ff[c];
      end

      case (state_ff)
         ST_ACCUM: begin
            if (req_accept && req_data.window_last) begin
               // Close the window: hand the sums to the divider and clear.
               // The sum is below count * 2^16, so its upper half is a
               // valid starting remainder.
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  div_rem_in[c]   = sum_upd[c][SUM_BITS-1:MEAN_BITS];
                  div_shift_in[c] = sum_upd[c][MEAN_BITS-1:0];
                  sum_in[c]       = '0;
               end
               divisor_in     = count_upd;
               div_dropped_in = dropped_upd;
               count_in       = '0;
               dropped_in     = 1'b0;
               step_in        = '0;
               state_in       = ST_DIV;
            end else if (req_accept) begin
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  sum_in[c] = sum_upd[c];
               end
               count_in   = count_upd;
               dropped_in = dropped_upd;
            end
         end
         ST_DIV: begin
            // One quotient bit per channel per cycle, shifted in at the bottom.
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               if (trial[c] >= {1'b0, divisor_ff}) begin
                  div_rem_in[c]   = MEAN_BITS'(trial[c] - {1'b0, divisor_ff});
                  div_shift_in[c] = {div_shift_ff[c][MEAN_BITS-2:0], 1'b1};
               end else begin
                  div_rem_in[c]   = trial[c][MEAN_BITS-1:0];
                  div_shift_in[c] = {div_shift_ff[c][MEAN_BITS-2:0], 1'b0};
               end
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            // Blend the acceleration means and load the result register.
            if (rsp_free) begin
               smooth_x_in  = (mean[CH_X] >> 1) + (smooth_x_ff >> 1);
               smooth_y_in  = (mean[CH_Y] >> 1) + (smooth_y_ff >> 1);
               rsp_data_in.accel_x_smoothed  = smooth_x_in;
               rsp_data_in.accel_y_smoothed  = smooth_y_in;
               rsp_data_in.throttle_mean     = mean[CH_THROTTLE];
               rsp_data_in.window_overflowed = div_dropped_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   // State, accumulators and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         smooth_x_ff  <= '0;
         smooth_y_ff  <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            sum_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         smooth_x_ff  <= smooth_x_in;
         smooth_y_ff  <= smooth_y_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            sum_ff[c] <= sum_in[c];
         end
      end
      divisor_ff     <= divisor_in;
      div_dropped_ff <= div_dropped_in;
      rsp_data_ff    <= rsp_data_in;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         div_rem_ff[c]   <= div_rem_in[c];
         div_shift_ff[c] <= div_shift_in[c];
      end
   end

   // A closing beat starts the divider with a fresh window behind it.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.window_last)
      |=> (state_ff == ST_DIV && step_ff == '0 && count_ff == '0 && !dropped_ff))
      else $error("closing beat did not start the divider with a cleared window");

   // After its last step the divider moves on to the send cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && step_ff == LAST_STEP) |=> (state_ff == ST_SEND))
      else $error("divider did not finish after its last step");

   // A new result only appears out of the send cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND && rsp_free) |=> (rsp_valid && state_ff == ST_ACCUM))
      else $error("send cycle did not load the result register");

   // Samples are only taken while accumulating.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_SEND) |-> req_stall)
      else $error("input open while the divider is busy");

endmodule

`default_nettype wire
